FILE: rtl/summed_area_table_2d_defines.svh
// Assertion macros shared by the summed-area table RTL.
`ifndef SUMMED_AREA_TABLE_2D_DEFINES_SVH
`define SUMMED_AREA_TABLE_2D_DEFINES_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define SAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAT_ASSERT(lbl, prop, msg)
`define SAT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/sat_pkg.sv
// Types, constants and codes shared by the summed-area table modules.
package sat_pkg;

  // Grid limits (defaults of the top-level parameters, at most 64 each)
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths
  localparam int VALUE_WIDTH = 32;
  localparam int SUM_WIDTH   = 48;
  localparam int COORD_W     = 6;
  localparam int DIM_W       = 7;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILL_VALUE  = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = 7'd64;
  localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BUILD = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_PHASE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_ADD_RD,
    S_ADD_WR,
    S_BUILD_RD,
    S_BUILD_WR,
    S_QRY_A,
    S_QRY_B,
    S_QRY_C,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                           op;
    logic [COORD_W-1:0]            row;
    logic [COORD_W-1:0]            col;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [DIM_W-1:0]              row_lo;
    logic [DIM_W-1:0]              row_hi;
    logic [DIM_W-1:0]              col_lo;
    logic [DIM_W-1:0]              col_hi;
  } sat_in_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] region_sum;
    logic [1:0]                  status;
  } sat_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic idle;
    logic sweep;
    logic sweep_zero;
    logic add_rd;
    logic add_wr;
    logic build_rd;
    logic build_wr;
    logic qry_a;
    logic qry_b;
    logic qry_c;
    logic load_out;
  } sat_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic    item_valid;
    op_t     op;
    status_t check;
    logic    sweep_last;
    logic    build_last;
    logic    out_free;
  } sat_sts_t;

endpackage

FILE: rtl/sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sat_ctrl.sv
// Controller state machine of the summed-area table.
`include "summed_area_table_2d_defines.svh"

module sat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  sat_pkg::sat_sts_t sts,
  output sat_pkg::sat_cmd_t cmd
);

  sat_pkg::state_t state;
  sat_pkg::state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sat_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sat_pkg::S_INIT: begin
        if (sts.sweep_last) state_next = sat_pkg::S_IDLE;
      end
      sat_pkg::S_IDLE: begin
        if (sts.item_valid) begin
          if (sts.check != sat_pkg::ST_OK) begin
            state_next = sat_pkg::S_DONE;
          end else begin
            unique case (sts.op)
              sat_pkg::OP_CLEAR: state_next = sat_pkg::S_CLEAR;
              sat_pkg::OP_ADD:   state_next = sat_pkg::S_ADD_RD;
              sat_pkg::OP_BUILD: state_next = sat_pkg::S_BUILD_RD;
              sat_pkg::OP_QUERY: state_next = sat_pkg::S_QRY_A;
            endcase
          end
        end
      end
      sat_pkg::S_CLEAR: begin
        if (sts.sweep_last) state_next = sat_pkg::S_DONE;
      end
      sat_pkg::S_ADD_RD:   state_next = sat_pkg::S_ADD_WR;
      sat_pkg::S_ADD_WR:   state_next = sat_pkg::S_DONE;
      sat_pkg::S_BUILD_RD: state_next = sat_pkg::S_BUILD_WR;
      sat_pkg::S_BUILD_WR: begin
        state_next = sts.build_last ? sat_pkg::S_DONE : sat_pkg::S_BUILD_RD;
      end
      sat_pkg::S_QRY_A:    state_next = sat_pkg::S_QRY_B;
      sat_pkg::S_QRY_B:    state_next = sat_pkg::S_QRY_C;
      sat_pkg::S_QRY_C:    state_next = sat_pkg::S_DONE;
      sat_pkg::S_DONE: begin
        if (sts.out_free) state_next = sat_pkg::S_IDLE;
      end
      default:             state_next = sat_pkg::S_IDLE;
    endcase
  end

  // Decode commands
  always_comb begin
    cmd = '0;
    unique case (state)
      sat_pkg::S_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
      end
      sat_pkg::S_IDLE:     cmd.idle     = 1'b1;
      sat_pkg::S_CLEAR:    cmd.sweep    = 1'b1;
      sat_pkg::S_ADD_RD:   cmd.add_rd   = 1'b1;
      sat_pkg::S_ADD_WR:   cmd.add_wr   = 1'b1;
      sat_pkg::S_BUILD_RD: cmd.build_rd = 1'b1;
      sat_pkg::S_BUILD_WR: cmd.build_wr = 1'b1;
      sat_pkg::S_QRY_A:    cmd.qry_a    = 1'b1;
      sat_pkg::S_QRY_B:    cmd.qry_b    = 1'b1;
      sat_pkg::S_QRY_C:    cmd.qry_c    = 1'b1;
      sat_pkg::S_DONE:     cmd.load_out = sts.out_free;
      default:             cmd = '0;
    endcase
  end

  `SAT_ASSERT(a_error_goes_done, cmd.idle && sts.item_valid && sts.check != sat_pkg::ST_OK |=> state == sat_pkg::S_DONE, "rejected item did not go straight to result")
  `SAT_ASSERT(a_done_holds, state == sat_pkg::S_DONE && !sts.out_free |=> state == sat_pkg::S_DONE, "result dropped while output slot busy")

endmodule

FILE: rtl/sat_dp.sv
// Datapath of the summed-area table: registers, checks, stores and adders.
`include "summed_area_table_2d_defines.svh"

module sat_dp #(
  parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sat_pkg::sat_cmd_t                     cmd,
  output sat_pkg::sat_sts_t                     sts,
  input  logic                                  cfg_write,
  input  logic [sat_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sat_pkg::VALUE_WIDTH-1:0]       cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  sat_pkg::sat_in_t                      item,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output sat_pkg::sat_out_t                     result
);

  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RA_W + CA_W;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = sat_pkg::DIM_W;
  localparam int VW    = sat_pkg::VALUE_WIDTH;
  localparam int SW    = sat_pkg::SUM_WIDTH;
  localparam logic [DW-1:0] MAX_R = DW'(MAX_ROWS);
  localparam logic [DW-1:0] MAX_C = DW'(MAX_COLS);
  localparam logic [DW-1:0] ONE   = DW'(1);

  // Configuration registers
  logic [DW-1:0] grid_height;
  logic [DW-1:0] grid_width;
  logic [VW-1:0] fill_value;

  // Effective sizes and item check
  logic [DW-1:0]    h_eff;
  logic [DW-1:0]    w_eff;
  sat_pkg::status_t check;
  logic             take;

  // Item register
  sat_pkg::op_t     item_op;
  sat_pkg::status_t item_status;
  logic [RA_W-1:0]  item_row;
  logic [CA_W-1:0]  item_col;
  logic [VW-1:0]    item_value;
  logic [DW-1:0]    q_r1;
  logic [DW-1:0]    q_r2;
  logic [DW-1:0]    q_c1;
  logic [DW-1:0]    q_c2;

  // Table state
  logic          sums_ready;
  logic [DW-1:0] bh;
  logic [DW-1:0] bw;
  logic [AW-1:0] sweep_cnt;

  // Build walk
  logic [RA_W-1:0] bi;
  logic [CA_W-1:0] bj;
  logic [SW-1:0]   rowsum;
  logic [SW-1:0]   rowsum_next;
  logic [SW-1:0]   cell_ext;
  logic            bj_last;
  logic            bi_last;

  // Memory ports
  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  logic [VW-1:0] cell_wdata;
  logic [AW-1:0] cell_raddr;
  logic [VW-1:0] cell_rdata;
  logic [AW-1:0] pfx_waddr;
  logic [SW-1:0] pfx_wdata;
  logic [AW-1:0] p0_raddr;
  logic [AW-1:0] p1_raddr;
  logic [SW-1:0] p0_rdata;
  logic [SW-1:0] p1_rdata;
  logic          z0;
  logic          z1;
  logic [SW-1:0] v0;
  logic [SW-1:0] v1;
  logic [SW-1:0] acc;

  // Prefix entry (r, c), 1-based, sits at address (r-1, c-1)
  function automatic logic [AW-1:0] pfx_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
    logic [DW-1:0] rm;
    logic [DW-1:0] cm;
    rm = r - ONE;
    cm = c - ONE;
    return {rm[RA_W-1:0], cm[CA_W-1:0]};
  endfunction

  // Border row and column, and anything past the built extent, read as zero
  function automatic logic pfx_zero(input logic [DW-1:0] r, input logic [DW-1:0] c,
                                    input logic [DW-1:0] hb, input logic [DW-1:0] wb);
    return (r == '0) || (c == '0) || (r > hb) || (c > wb);
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= sat_pkg::RST_GRID_HEIGHT;
      grid_width  <= sat_pkg::RST_GRID_WIDTH;
      fill_value  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sat_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[DW-1:0];
        sat_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[DW-1:0];
        sat_pkg::CFG_FILL_VALUE:  fill_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1..max
  always_comb begin
    h_eff = (grid_height == '0) ? ONE : ((grid_height > MAX_R) ? MAX_R : grid_height);
    w_eff = (grid_width == '0) ? ONE : ((grid_width > MAX_C) ? MAX_C : grid_width);
  end

  // Check an incoming item: range first, then phase
  always_comb begin
    check = sat_pkg::ST_OK;
    unique case (item.op)
      sat_pkg::OP_CLEAR: check = sat_pkg::ST_OK;
      sat_pkg::OP_ADD: begin
        if (DW'(item.row) >= h_eff || DW'(item.col) >= w_eff) begin
          check = sat_pkg::ST_RANGE;
        end else if (sums_ready) begin
          check = sat_pkg::ST_PHASE;
        end
      end
      sat_pkg::OP_BUILD: begin
        if (sums_ready) check = sat_pkg::ST_PHASE;
      end
      sat_pkg::OP_QUERY: begin
        if (item.row_lo > item.row_hi || item.row_hi > h_eff ||
            item.col_lo > item.col_hi || item.col_hi > w_eff) begin
          check = sat_pkg::ST_RANGE;
        end else if (!sums_ready) begin
          check = sat_pkg::ST_PHASE;
        end
      end
    endcase
  end

  assign item_ready = cmd.idle;
  assign take       = cmd.idle && item_valid;

  // Report to the controller
  always_comb begin
    sts.item_valid = item_valid;
    sts.op         = item.op;
    sts.check      = check;
    sts.sweep_last = &sweep_cnt;
    sts.build_last = bj_last && bi_last;
    sts.out_free   = !result_valid || result_ready;
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (take) begin
      item_op     <= item.op;
      item_status <= check;
      item_row    <= item.row[RA_W-1:0];
      item_col    <= item.col[CA_W-1:0];
      item_value  <= item.value;
      q_r1        <= item.row_lo;
      q_r2        <= item.row_hi;
      q_c1        <= item.col_lo;
      q_c2        <= item.col_hi;
    end
  end

  // Track built state, sweep position and result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      sums_ready   <= 1'b0;
      sweep_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        sweep_cnt <= '0;
        if (check == sat_pkg::ST_OK && item.op == sat_pkg::OP_CLEAR) sums_ready <= 1'b0;
        if (check == sat_pkg::ST_OK && item.op == sat_pkg::OP_BUILD) sums_ready <= 1'b1;
      end else if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the result item
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.region_sum <= (item_op == sat_pkg::OP_QUERY && item_status == sat_pkg::ST_OK) ?
                           acc : '0;
      result.status     <= item_status;
    end
  end

  // Build walk: row-major over the grid, keeping the running row sum
  assign bj_last     = (DW'(bj) == bw - ONE);
  assign bi_last     = (DW'(bi) == bh - ONE);
  assign cell_ext    = {{(SW - VW){cell_rdata[VW-1]}}, cell_rdata};
  assign rowsum_next = rowsum + cell_ext;
  assign v0          = z0 ? '0 : p0_rdata;
  assign v1          = z1 ? '0 : p1_rdata;
  assign pfx_wdata   = v0 + rowsum_next;
  assign pfx_waddr   = {bi, bj};

  // Record the built extent only on an accepted build; it bounds later queries
  always_ff @(posedge clk) begin
    if (take) begin
      if (check == sat_pkg::ST_OK && item.op == sat_pkg::OP_BUILD) begin
        bh <= h_eff;
        bw <= w_eff;
      end
      bi     <= '0;
      bj     <= '0;
      rowsum <= '0;
    end else if (cmd.build_wr) begin
      if (bj_last) begin
        bj     <= '0;
        bi     <= bi + RA_W'(1);
        rowsum <= '0;
      end else begin
        bj     <= bj + CA_W'(1);
        rowsum <= rowsum_next;
      end
    end
  end

  // Select prefix read addresses
  always_comb begin
    if (cmd.build_rd) begin
      p0_raddr = {bi - RA_W'(1), bj};
    end else if (cmd.qry_a) begin
      p0_raddr = pfx_addr(q_r2, q_c2);
    end else begin
      p0_raddr = pfx_addr(q_r2, q_c1);
    end
    p1_raddr = cmd.qry_a ? pfx_addr(q_r1, q_c2) : pfx_addr(q_r1, q_c1);
  end

  // Track which read data stands for a zero entry
  always_ff @(posedge clk) begin
    if (cmd.build_rd) begin
      z0 <= (bi == '0);
      z1 <= 1'b1;
    end else if (cmd.qry_a) begin
      z0 <= pfx_zero(q_r2, q_c2, bh, bw);
      z1 <= pfx_zero(q_r1, q_c2, bh, bw);
    end else if (cmd.qry_b) begin
      z0 <= pfx_zero(q_r2, q_c1, bh, bw);
      z1 <= pfx_zero(q_r1, q_c1, bh, bw);
    end
  end

  // Combine the four corners
  always_ff @(posedge clk) begin
    if (cmd.qry_b) begin
      acc <= v0 - v1;
    end else if (cmd.qry_c) begin
      acc <= acc - v0 + v1;
    end
  end

  // Cell store ports
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = sweep_cnt;
    cell_wdata = fill_value;
    if (cmd.sweep) begin
      cell_we    = 1'b1;
      cell_wdata = cmd.sweep_zero ? '0 : fill_value;
    end else if (cmd.add_wr) begin
      cell_we    = 1'b1;
      cell_waddr = {item_row, item_col};
      cell_wdata = cell_rdata + item_value;
    end
  end

  assign cell_raddr = cmd.add_rd ? {item_row, item_col} : {bi, bj};

  sat_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // Two copies of the prefix store give two reads per cycle
  sat_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_pfx_ram0 (
    .clk   (clk),
    .we    (cmd.build_wr),
    .waddr (pfx_waddr),
    .wdata (pfx_wdata),
    .raddr (p0_raddr),
    .rdata (p0_rdata)
  );

  sat_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_pfx_ram1 (
    .clk   (clk),
    .we    (cmd.build_wr),
    .waddr (pfx_waddr),
    .wdata (pfx_wdata),
    .raddr (p1_raddr),
    .rdata (p1_rdata)
  );

  `SAT_ASSERT_RST(a_reset_clears, rst |=> !result_valid && !sums_ready, "reset left a result or built state")
  `SAT_ASSERT(a_build_sets_ready, take && item.op == sat_pkg::OP_BUILD && check == sat_pkg::ST_OK |=> sums_ready, "build did not mark sums ready")
  `SAT_ASSERT(a_build_in_bounds, cmd.build_rd |-> (DW'(bi) < bh) && (DW'(bj) < bw), "build walk left the grid")
  `SAT_ASSERT(a_query_when_built, cmd.load_out && item_op == sat_pkg::OP_QUERY && item_status == sat_pkg::ST_OK |-> sums_ready, "query answered before build")

endmodule

FILE: rtl/summed_area_table_2d.sv
// Summed-area table: grid loading, one-time prefix build and rectangle queries.
// One item is in work at a time; a finished result waits in an output register
// while the next item is accepted. A rejected item (range or phase error) goes
// straight to the result; add does a cell read, then a write back; query does
// two rounds of two prefix reads from the duplicated prefix store, then a corner
// add; clear sweeps all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096 at the
// defaults), one cell store write per cycle; build does one cell and one prefix
// read, then one prefix write per grid cell. After reset the cell store is zeroed
// by the same sweep, during which no item is accepted; configuration writes are
// taken throughout. MAX_ROWS and MAX_COLS range over 1..64.
module summed_area_table_2d #(
  parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sat_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sat_pkg::VALUE_WIDTH-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  sat_pkg::sat_in_t                item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output sat_pkg::sat_out_t               result
);

  sat_pkg::sat_cmd_t cmd;
  sat_pkg::sat_sts_t sts;

  sat_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sat_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
